[src/mcg_pkg.sv]
// Package with the shared types and constants of the midpoint circle generator.
package mcg_pkg;

  typedef enum logic {
    FUNC_START = 1'b0,
    FUNC_STEP  = 1'b1
  } func_e;

  localparam int unsigned CoordW = 11;
  localparam int unsigned PointW = 12;
  localparam int unsigned QDepth = 2;
  localparam int unsigned PtrW   = 1;
  localparam int unsigned CntW   = 2;
  localparam logic [2:0]  LastIdx = 3'd7;

  typedef struct packed {
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] cy;
    logic signed [PointW-1:0] ox;
    logic signed [PointW-1:0] oy;
    logic                     done;
  } step_t;

endpackage

[src/mcg_front.sv]
// Front part: takes start and step items, runs the octant walk, queues step records.
module mcg_front #(
  parameter int unsigned RADIUS_BITS = 10
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  logic                              func_i,
  input  logic signed [mcg_pkg::CoordW-1:0] center_x_i,
  input  logic signed [mcg_pkg::CoordW-1:0] center_y_i,
  input  logic [9:0]                        radius_i,
  input  logic                              q_full_i,
  output logic                              q_push_o,
  output mcg_pkg::step_t                    q_data_o
);

  localparam int unsigned PosW = RADIUS_BITS + 1;
  localparam int unsigned DecW = RADIUS_BITS + 4;

  logic signed [PosW-1:0]           octant_x_q, octant_x_d;
  logic signed [PosW-1:0]           octant_y_q, octant_y_d;
  logic signed [DecW-1:0]           decision_q, decision_d;
  logic signed [mcg_pkg::CoordW-1:0] centre_x_q, centre_x_d;
  logic signed [mcg_pkg::CoordW-1:0] centre_y_q, centre_y_d;
  logic                             active_q, active_d;

  logic                   accept;
  logic                   is_step;
  logic [RADIUS_BITS-1:0] rad;
  logic signed [DecW-1:0] x_ext;
  logic signed [DecW-1:0] y_ext;
  logic signed [PosW-1:0] x_next;
  logic signed [PosW-1:0] y_next;
  logic signed [DecW-1:0] dec_next;
  logic                   done;

  assign full    = q_full_i;
  assign accept  = push && !q_full_i;
  assign is_step = (func_i == mcg_pkg::FUNC_STEP);
  assign rad     = RADIUS_BITS'(radius_i);
  assign x_ext   = DecW'(octant_x_q);
  assign y_ext   = DecW'(octant_y_q);

  always_comb begin
    x_next = octant_x_q + PosW'(1);
    if (decision_q[DecW-1]) begin
      y_next   = octant_y_q;
      dec_next = decision_q + (x_ext <<< 2) + DecW'(6);
    end else begin
      y_next   = octant_y_q - PosW'(1);
      dec_next = decision_q + ((x_ext - y_ext) <<< 2) + DecW'(10);
    end
    done = x_next > y_next;
  end

  always_comb begin
    octant_x_d = octant_x_q;
    octant_y_d = octant_y_q;
    decision_d = decision_q;
    centre_x_d = centre_x_q;
    centre_y_d = centre_y_q;
    active_d   = active_q;
    q_push_o   = 1'b0;
    if (accept) begin
      if (!is_step) begin
        centre_x_d = center_x_i;
        centre_y_d = center_y_i;
        octant_x_d = '0;
        octant_y_d = PosW'(rad);
        decision_d = DecW'(3) - (DecW'(rad) << 1);
        active_d   = 1'b1;
      end else if (active_q) begin
        q_push_o   = 1'b1;
        octant_x_d = x_next;
        octant_y_d = y_next;
        decision_d = dec_next;
        if (done) begin
          active_d = 1'b0;
        end
      end
    end
  end

  always_comb begin
    q_data_o.cx   = centre_x_q;
    q_data_o.cy   = centre_y_q;
    q_data_o.ox   = mcg_pkg::PointW'(octant_x_q);
    q_data_o.oy   = mcg_pkg::PointW'(octant_y_q);
    q_data_o.done = done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      octant_x_q <= '0;
      octant_y_q <= '0;
      decision_q <= '0;
      centre_x_q <= '0;
      centre_y_q <= '0;
      active_q   <= 1'b0;
    end else begin
      octant_x_q <= octant_x_d;
      octant_y_q <= octant_y_d;
      decision_q <= decision_d;
      centre_x_q <= centre_x_d;
      centre_y_q <= centre_y_d;
      active_q   <= active_d;
    end
  end

endmodule

[src/mcg_queue.sv]
// Two-entry queue of step records between the front and back parts.
module mcg_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mcg_pkg::step_t data_i,
  output logic           full_o,
  output logic           valid_o,
  input  logic           pop_i,
  output mcg_pkg::step_t data_o
);

  mcg_pkg::step_t              mem_q [mcg_pkg::QDepth];
  logic [mcg_pkg::PtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [mcg_pkg::PtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [mcg_pkg::CntW-1:0]    count_q, count_d;
  logic                        do_push;
  logic                        do_pop;

  assign full_o  = (count_q == mcg_pkg::CntW'(mcg_pkg::QDepth));
  assign valid_o = (count_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

[src/mcg_back.sv]
// Back part: expands each step record into eight points held in an output register.
module mcg_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              q_valid_i,
  input  mcg_pkg::step_t                    q_data_i,
  output logic                              q_pop_o,
  output logic                              empty,
  input  logic                              pop,
  output logic signed [mcg_pkg::PointW-1:0] point_x_o,
  output logic signed [mcg_pkg::PointW-1:0] point_y_o,
  output logic                              last_of_step_o,
  output logic                              circle_done_o
);

  logic [2:0]                        idx_q, idx_d;
  logic                              out_valid_q, out_valid_d;
  logic signed [mcg_pkg::PointW-1:0] px_q, py_q;
  logic                              last_q, done_q;
  logic signed [mcg_pkg::PointW-1:0] dx, dy, px_d, py_d;
  logic                              load;
  logic                              taken;

  assign empty = !out_valid_q;
  assign taken = pop && out_valid_q;
  assign load  = q_valid_i && (!out_valid_q || taken);
  assign q_pop_o = load && (idx_q == mcg_pkg::LastIdx);

  always_comb begin
    case (idx_q)
      3'd0: begin dx = q_data_i.ox;  dy = q_data_i.oy;  end
      3'd1: begin dx = q_data_i.oy;  dy = q_data_i.ox;  end
      3'd2: begin dx = q_data_i.ox;  dy = -q_data_i.oy; end
      3'd3: begin dx = q_data_i.oy;  dy = -q_data_i.ox; end
      3'd4: begin dx = -q_data_i.ox; dy = -q_data_i.oy; end
      3'd5: begin dx = -q_data_i.oy; dy = -q_data_i.ox; end
      3'd6: begin dx = -q_data_i.ox; dy = q_data_i.oy;  end
      default: begin dx = -q_data_i.oy; dy = q_data_i.ox; end
    endcase
    px_d = mcg_pkg::PointW'(q_data_i.cx) + dx;
    py_d = mcg_pkg::PointW'(q_data_i.cy) + dy;
  end

  always_comb begin
    idx_d       = load ? idx_q + 3'd1 : idx_q;
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (taken) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      px_q   <= px_d;
      py_q   <= py_d;
      last_q <= (idx_q == mcg_pkg::LastIdx);
      done_q <= q_data_i.done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign point_x_o      = px_q;
  assign point_y_o      = py_q;
  assign last_of_step_o = last_q;
  assign circle_done_o  = done_q;

endmodule

[src/midpoint_circle_generator.sv]
// Top level of the midpoint circle generator.
// A start item (func 0) latches the centre and radius and gives no result.
// Each step item (func 1) on an active circle yields eight points, one per cycle while pop
// is held, so the sustained step rate is set by the single result port. A
// two-entry queue of step records sits between the walk and the point expander, and an
// output register holds the oldest point; items are taken while results wait, until full.
module midpoint_circle_generator #(
  parameter int unsigned RADIUS_BITS = 10
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  logic                              func_i,
  input  logic signed [10:0]                center_x_i,
  input  logic signed [10:0]                center_y_i,
  input  logic [9:0]                        radius_i,
  output logic                              empty,
  input  logic                              pop,
  output logic signed [11:0]                point_x_o,
  output logic signed [11:0]                point_y_o,
  output logic                              last_of_step_o,
  output logic                              circle_done_o
);

  logic           q_push;
  logic           q_full;
  logic           q_valid;
  logic           q_pop;
  mcg_pkg::step_t q_wdata;
  mcg_pkg::step_t q_rdata;

  mcg_front #(
    .RADIUS_BITS(RADIUS_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .func_i     (func_i),
    .center_x_i (center_x_i),
    .center_y_i (center_y_i),
    .radius_i   (radius_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_wdata)
  );

  mcg_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .data_o  (q_rdata)
  );

  mcg_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_data_i       (q_rdata),
    .q_pop_o        (q_pop),
    .empty          (empty),
    .pop            (pop),
    .point_x_o      (point_x_o),
    .point_y_o      (point_y_o),
    .last_of_step_o (last_of_step_o),
    .circle_done_o  (circle_done_o)
  );

endmodule

[dv/tb_midpoint_circle_generator.sv]
// Self-checking testbench for the midpoint circle generator with a built-in point predictor.
module tb_midpoint_circle_generator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RadiusBits = 10;
  localparam int PosW       = RadiusBits + 1;
  localparam int DecW       = RadiusBits + 4;
  localparam int CoordW     = mcg_pkg::CoordW;
  localparam int PointW     = mcg_pkg::PointW;
  localparam int HoldCycles = 400;
  localparam int DrainLimit = 200000;

  typedef struct {
    mcg_pkg::func_e func;
    int             cx;
    int             cy;
    int             rad;
    bit             typed;
    int             tx;
    int             ty;
  } stim_t;

  typedef struct packed {
    logic signed [PointW-1:0] px;
    logic signed [PointW-1:0] py;
    logic                     last;
    logic                     done;
  } point_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     push = 1'b0;
  logic                     full;
  logic                     func_i = 1'b0;
  logic signed [10:0]       center_x_i = '0;
  logic signed [10:0]       center_y_i = '0;
  logic [9:0]               radius_i = '0;
  logic                     empty;
  logic                     pop = 1'b0;
  logic signed [11:0]       point_x_o;
  logic signed [11:0]       point_y_o;
  logic                     last_of_step_o;
  logic                     circle_done_o;

  logic signed [PosW-1:0]   oct_x = '0;
  logic signed [PosW-1:0]   oct_y = '0;
  logic signed [DecW-1:0]   dec = '0;
  logic signed [CoordW-1:0] cen_x = '0;
  logic signed [CoordW-1:0] cen_y = '0;
  bit                       walk_active = 1'b0;

  point_t expected_points[$];
  int     errors = 0;
  int     items_used = 0;
  int     send_idle_pct = 0;
  int     recv_idle_pct = 0;
  bit     hold_req = 1'b0;
  bit     hold_taken = 1'b0;
  int     hold_left = 0;

  stim_t directed_stim [21] = '{
    '{mcg_pkg::FUNC_STEP,      0,     0,    0, 1'b0,     0,     0},
    '{mcg_pkg::FUNC_START, -1024,  1023,    0, 1'b0,     0,     0},
    '{mcg_pkg::FUNC_STEP,      0,     0,    0, 1'b1, -1024,  1023},
    '{mcg_pkg::FUNC_STEP,   1023,  1023, 1023, 1'b0,     0,     0},
    '{mcg_pkg::FUNC_START,  1023, -1024,    0, 1'b0,     0,     0},
    '{mcg_pkg::FUNC_STEP,  -1024, -1024, 1023, 1'b1,  1023, -1024},
    '{mcg_pkg::FUNC_START,     0,     0,    1, 1'b0,     0,     0},
    '{mcg_pkg::FUNC_STEP,      0,     0,    0, 1'b0,     0,     0},
    '{mcg_pkg::FUNC_STEP,      0,     0,    0, 1'b0,     0,     0},
    '{mcg_pkg::FUNC_START,     5,    -7,    3, 1'b0,     0,     0},
    '{mcg_pkg::FUNC_STEP,      0,     0,    0, 1'b0,     0,     0},
    '{mcg_pkg::FUNC_START,  1023,  1023, 1023, 1'b0,     0,     0},
    '{mcg_pkg::FUNC_STEP,      0,     0,    0, 1'b0,     0,     0},
    '{mcg_pkg::FUNC_STEP,      0,     0,    0, 1'b0,     0,     0},
    '{mcg_pkg::FUNC_START, -1024, -1024, 1023, 1'b0,     0,     0},
    '{mcg_pkg::FUNC_STEP,      0,     0,    0, 1'b0,     0,     0},
    '{mcg_pkg::FUNC_STEP,      0,     0,    0, 1'b0,     0,     0},
    '{mcg_pkg::FUNC_START,    -3,     4,    2, 1'b0,     0,     0},
    '{mcg_pkg::FUNC_STEP,      0,     0,    0, 1'b0,     0,     0},
    '{mcg_pkg::FUNC_STEP,      0,     0,    0, 1'b0,     0,     0},
    '{mcg_pkg::FUNC_STEP,      0,     0,    0, 1'b0,     0,     0}
  };

  midpoint_circle_generator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .func_i         (func_i),
    .center_x_i     (center_x_i),
    .center_y_i     (center_y_i),
    .radius_i       (radius_i),
    .empty          (empty),
    .pop            (pop),
    .point_x_o      (point_x_o),
    .point_y_o      (point_y_o),
    .last_of_step_o (last_of_step_o),
    .circle_done_o  (circle_done_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic void walk_circle(input stim_t it);
    int     x;
    int     y;
    int     d;
    int     dx[8];
    int     dy[8];
    logic   done;
    point_t pt;
    if (it.func == mcg_pkg::FUNC_START) begin
      cen_x = CoordW'(it.cx);
      cen_y = CoordW'(it.cy);
      oct_x = '0;
      oct_y = PosW'(it.rad);
      dec = DecW'(3 - 2 * it.rad);
      walk_active = 1'b1;
      items_used++;
      return;
    end
    if (!walk_active) begin
      return;
    end
    items_used++;
    x = oct_x;
    y = oct_y;
    d = dec;
    if (d < 0) begin
      d = d + 4 * x + 6;
    end else begin
      d = d + 4 * (x - y) + 10;
      oct_y = PosW'(y - 1);
    end
    oct_x = PosW'(x + 1);
    dec = DecW'(d);
    done = (oct_x > oct_y);
    if (done) begin
      walk_active = 1'b0;
    end
    dx = '{x, y, x, y, -x, -y, -x, -y};
    dy = '{y, x, -y, -x, -y, -x, y, x};
    for (int k = 0; k < 8; k++) begin
      pt.px = PointW'(int'(cen_x) + dx[k]);
      pt.py = PointW'(int'(cen_y) + dy[k]);
      pt.last = (k == 7);
      pt.done = done;
      if (it.typed) begin
        pt.px = PointW'(it.tx);
        pt.py = PointW'(it.ty);
        pt.done = 1'b1;
      end
      expected_points.push_back(pt);
    end
  endfunction

  task automatic send_item(input stim_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push <= 1'b1;
    func_i <= it.func;
    center_x_i <= 11'(it.cx);
    center_y_i <= 11'(it.cy);
    radius_i <= 10'(it.rad);
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    walk_circle(it);
    @(negedge clk_i);
  endtask

  task automatic random_circle();
    stim_t it;
    int    steps;
    it.typed = 1'b0;
    it.tx = 0;
    it.ty = 0;
    it.cx = int'($urandom_range(0, 2047)) - 1024;
    it.cy = int'($urandom_range(0, 2047)) - 1024;
    it.rad = $urandom_range(0, 1023);
    if ($urandom_range(0, 9) == 0) begin
      it.func = mcg_pkg::func_e'($urandom_range(0, 1));
      send_item(it);
      return;
    end
    it.func = mcg_pkg::FUNC_START;
    if ($urandom_range(0, 4) != 0) begin
      it.rad = $urandom_range(0, 15);
    end
    steps = (it.rad > 15) ? $urandom_range(1, 4) : 64;
    if ($urandom_range(0, 4) == 0) begin
      steps = $urandom_range(0, 3);
    end
    send_item(it);
    it.func = mcg_pkg::FUNC_STEP;
    while (walk_active && steps > 0) begin
      it.cx = int'($urandom_range(0, 2047)) - 1024;
      it.cy = int'($urandom_range(0, 2047)) - 1024;
      it.rad = $urandom_range(0, 1023);
      send_item(it);
      steps--;
    end
    if ($urandom_range(0, 3) == 0) begin
      send_item(it);
    end
  endtask

  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    point_t got;
    point_t want;
    if (rst_ni && pop && !empty) begin
      got = '{point_x_o, point_y_o, last_of_step_o, circle_done_o};
      if (expected_points.size() == 0) begin
        errors++;
        $display("%0t: unexpected point x=%0d y=%0d last=%0b done=%0b", $time,
                 got.px, got.py, got.last, got.done);
      end else begin
        want = expected_points.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: point mismatch, expected x=%0d y=%0d last=%0b done=%0b,",
                   $time, want.px, want.py, want.last, want.done,
                   " got x=%0d y=%0d last=%0b done=%0b",
                   got.px, got.py, got.last, got.done);
        end
      end
    end
  end

  initial begin
    int drain;
    int target;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    send_idle_pct = 10;
    recv_idle_pct = 72;
    foreach (directed_stim[i]) begin
      send_item(directed_stim[i]);
    end
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 10 : (phase == 1) ? 72 : 0;
      recv_idle_pct = (phase == 0) ? 72 : (phase == 1) ? 10 : 0;
      if (phase == 2) begin
        hold_req = 1'b1;
      end
      target = items_used + 63;
      while (items_used < target) begin
        random_circle();
      end
    end
    push <= 1'b0;
    drain = 0;
    while (expected_points.size() != 0 && drain < DrainLimit) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (20) @(posedge clk_i);
    if (expected_points.size() != 0) begin
      errors++;
      $display("%0t: %0d expected points never arrived, next x=%0d y=%0d", $time,
               expected_points.size(), expected_points[0].px, expected_points[0].py);
    end
    if (errors == 0) begin
      $display("[midpoint_circle_generator] OK");
    end else begin
      $display("[midpoint_circle_generator] ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[midpoint_circle_generator] ERROR");
    $finish;
  end

endmodule
